>>> sv/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg: shared constants and types for the biquad filter
// Default widths, register index codes and fixed datapath sizes.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 16;
  localparam int ACC_BITS_DEF    = 32;

  localparam int OUT_BITS     = 32;
  localparam int SHIFT_BITS   = 5;
  localparam int RES_BITS     = 30;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [SHIFT_BITS-1:0] MAX_SHIFT = SHIFT_BITS'(30);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COEF_B0    = 3'd0,
    REG_COEF_B1    = 3'd1,
    REG_COEF_B2    = 3'd2,
    REG_COEF_A1    = 3'd3,
    REG_COEF_A2    = 3'd4,
    REG_FRAC_SHIFT = 3'd5
  } cfg_reg_e;

  // shift amounts above the supported range clamp to the maximum
  function automatic logic [SHIFT_BITS-1:0] clamp_shift(input logic [SHIFT_BITS-1:0] s);
    return (s > MAX_SHIFT) ? MAX_SHIFT : s;
  endfunction

endpackage

>>> sv/biq_front.sv
// ----------------------------------------------------------------------------
// biq_front: input request queue
// Two-entry queue that takes samples from the input channel and hands
// them to the datapath; stalls the input only when full.
// ----------------------------------------------------------------------------
module biq_front #(
  parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_in_i,
  output logic                   q_valid_o,
  output logic [SAMPLE_BITS-1:0] q_sample_o,
  input  logic                   q_pop_i
);

  logic [SAMPLE_BITS-1:0] mem_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_sample_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push    ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= sample_in_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule

>>> sv/biq_back.sv
// ----------------------------------------------------------------------------
// biq_back: biquad datapath
// Coefficient registers, filter history, residue feedback and the
// output register. One sample per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module biq_back #(
  parameter int SAMPLE_BITS   = biq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS     = biq_pkg::COEF_BITS_DEF,
  parameter int ACC_BITS      = biq_pkg::ACC_BITS_DEF,
  parameter int CFG_DATA_BITS = COEF_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [biq_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]           cfg_wdata_i,
  input  logic                               q_valid_i,
  input  logic [SAMPLE_BITS-1:0]             q_sample_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [biq_pkg::OUT_BITS-1:0]       sample_out_o
);

  localparam int OB = biq_pkg::OUT_BITS;
  localparam int RB = biq_pkg::RES_BITS;
  localparam int SB = biq_pkg::SHIFT_BITS;

  logic signed [COEF_BITS-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic        [SB-1:0]          shift_q;
  logic signed [SAMPLE_BITS-1:0] x1_q, x2_q;
  logic signed [OB-1:0]          y1_q, y2_q;
  logic        [RB-1:0]          res_q, res_d;
  logic                          out_valid_q;
  logic        [OB-1:0]          out_data_q;

  logic signed [SAMPLE_BITS-1:0] xs;
  logic signed [ACC_BITS-1:0]    xe, x1e, x2e, y1e, y2e;
  logic signed [ACC_BITS-1:0]    b0e, b1e, b2e, a1e, a2e;
  logic        [ACC_BITS-1:0]    pb0, pb1, pb2, pa1, pa2;
  logic        [ACC_BITS-1:0]    acc;
  logic        [SB-1:0]          q_eff;
  logic        [OB-1:0]          y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q    <= '0;
      b1_q    <= '0;
      b2_q    <= '0;
      a1_q    <= '0;
      a2_q    <= '0;
      shift_q <= '0;
    end else if (cfg_we_i) begin
      case (biq_pkg::cfg_reg_e'(cfg_idx_i))
        biq_pkg::REG_COEF_B0:    b0_q    <= cfg_wdata_i[COEF_BITS-1:0];
        biq_pkg::REG_COEF_B1:    b1_q    <= cfg_wdata_i[COEF_BITS-1:0];
        biq_pkg::REG_COEF_B2:    b2_q    <= cfg_wdata_i[COEF_BITS-1:0];
        biq_pkg::REG_COEF_A1:    a1_q    <= cfg_wdata_i[COEF_BITS-1:0];
        biq_pkg::REG_COEF_A2:    a2_q    <= cfg_wdata_i[COEF_BITS-1:0];
        biq_pkg::REG_FRAC_SHIFT: shift_q <= cfg_wdata_i[SB-1:0];
        default: ;
      endcase
    end
  end

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);
  assign xs      = q_sample_i;

  assign xe  = xs;
  assign x1e = x1_q;
  assign x2e = x2_q;
  assign y1e = y1_q;
  assign y2e = y2_q;
  assign b0e = b0_q;
  assign b1e = b1_q;
  assign b2e = b2_q;
  assign a1e = a1_q;
  assign a2e = a2_q;

  assign pb0 = b0e * xe;
  assign pb1 = b1e * x1e;
  assign pb2 = b2e * x2e;
  assign pa1 = a1e * y1e;
  assign pa2 = a2e * y2e;

  assign q_eff = biq_pkg::clamp_shift(shift_q);
  assign acc   = pb0 + pb1 + pb2 - pa1 - pa2 + {{(ACC_BITS-RB){1'b0}}, res_q};
  assign y_d   = OB'($signed(acc) >>> q_eff);
  assign res_d = RB'(acc & ~({ACC_BITS{1'b1}} << q_eff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        x1_q  <= xs;
        x2_q  <= x1_q;
        y1_q  <= y_d;
        y2_q  <= y1_q;
        res_q <= res_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= y_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

  a_pop_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> out_valid_q) else $error("popped sample produced no result");

  a_feedback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (y1_q == out_data_q) && (y2_q == $past(y1_q)))
    else $error("output history out of step");

  a_residue_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (({{(ACC_BITS-RB){1'b0}}, res_q} >> $past(q_eff)) == '0))
    else $error("residue wider than shift");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !q_pop_o)
    else $error("held result overwritten");

endmodule

>>> sv/biquad_iir_filter_with_residue.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter_with_residue: direct form 1 biquad with error feedback
// y = (b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 + residue) >>> frac_shift,
// the shifted-out bits are fed back as the next residue.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------
//   input    | in        | in_valid_i/in_stall_o  | sample_in_i
//   output   | out       | out_valid_o/out_stall_i| sample_out_o
//   config   | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One sample per cycle while the output is not stalled; a request accepted into
// the two-entry input queue is popped from it into the output register when the
// output register is free or its result is being taken.
// The rate is set by the loop through the output history multipliers.
// Reset clears coefficients, shift, history, residue, the queue and output valid.
// A stalled output holds its result; the input stalls only when the queue fills.
// ----------------------------------------------------------------------------
module biquad_iir_filter_with_residue #(
  parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = biq_pkg::COEF_BITS_DEF,
  parameter int ACC_BITS    = biq_pkg::ACC_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [biq_pkg::CFG_IDX_BITS-1:0]             cfg_idx_i,
  input  logic [((COEF_BITS > biq_pkg::SHIFT_BITS) ?
                 COEF_BITS : biq_pkg::SHIFT_BITS)-1:0] cfg_wdata_i,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  logic [SAMPLE_BITS-1:0]                       sample_in_i,
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output logic [biq_pkg::OUT_BITS-1:0]                 sample_out_o
);

  localparam int CfgDataBits = (COEF_BITS > biq_pkg::SHIFT_BITS) ?
                               COEF_BITS : biq_pkg::SHIFT_BITS;

  logic                   q_valid;
  logic [SAMPLE_BITS-1:0] q_sample;
  logic                   q_pop;

  biq_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_in_i(sample_in_i),
    .q_valid_o  (q_valid),
    .q_sample_o (q_sample),
    .q_pop_i    (q_pop)
  );

  biq_back #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .COEF_BITS    (COEF_BITS),
    .ACC_BITS     (ACC_BITS),
    .CFG_DATA_BITS(CfgDataBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_sample_i  (q_sample),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o)
  );

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the biquad filter with residue feedback
// Programs coefficient and shift settings while the filter is idle, streams
// directed and random samples with random idle bursts on both channels, and
// checks each output against a cycle-free model of the filter arithmetic.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_W = (biq_pkg::COEF_BITS_DEF > biq_pkg::SHIFT_BITS) ?
                         biq_pkg::COEF_BITS_DEF : biq_pkg::SHIFT_BITS;

  class iir_scoreboard;
    logic signed [15:0] b0 = '0, b1 = '0, b2 = '0, a1 = '0, a2 = '0;
    logic [biq_pkg::SHIFT_BITS-1:0] shift = '0;
    logic signed [15:0] x1 = '0, x2 = '0;
    logic signed [31:0] y1 = '0, y2 = '0;
    logic [biq_pkg::RES_BITS-1:0] residue = '0;
    logic [31:0] expected_q[$];
    int errors = 0;

    function void write_reg(biq_pkg::cfg_reg_e idx, logic [CFG_W-1:0] d);
      case (idx)
        biq_pkg::REG_COEF_B0:    b0 = d[15:0];
        biq_pkg::REG_COEF_B1:    b1 = d[15:0];
        biq_pkg::REG_COEF_B2:    b2 = d[15:0];
        biq_pkg::REG_COEF_A1:    a1 = d[15:0];
        biq_pkg::REG_COEF_A2:    a2 = d[15:0];
        biq_pkg::REG_FRAC_SHIFT: shift = d[biq_pkg::SHIFT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [15:0] x);
      longint signed sum;
      logic signed [31:0] acc;
      logic [31:0] y;
      logic [biq_pkg::SHIFT_BITS-1:0] q;
      q = (shift > biq_pkg::MAX_SHIFT) ? biq_pkg::MAX_SHIFT : shift;
      sum = longint'(b0) * longint'(x) + longint'(b1) * longint'(x1)
          + longint'(b2) * longint'(x2) - longint'(a1) * longint'(y1)
          - longint'(a2) * longint'(y2) + longint'(residue);
      acc = sum[31:0];
      y = 32'(acc >>> q);
      residue = biq_pkg::RES_BITS'(acc & ((32'd1 << q) - 32'd1));
      x2 = x1;
      x1 = x;
      y2 = y1;
      y1 = y;
      expected_q.push_back(y);
    endfunction

    function void check_output(logic [31:0] y);
      logic [31:0] e;
      if (expected_q.size() == 0) begin
        $display("%t unexpected sample_out: actual %0d", $time, $signed(y));
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e !== y) begin
          $display("%t sample_out mismatch: expected %0d actual %0d",
                   $time, $signed(e), $signed(y));
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [biq_pkg::CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] sample_out;

  bit idle_en = 1'b1;
  int stall_left = 0;
  iir_scoreboard sb = new;

  biquad_iir_filter_with_residue DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_in_i (sample_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .sample_out_o(sample_out)
  );

  always #5 clk = ~clk;

  // output side: check accepted results, then pick the next stall
  always @(posedge clk) begin
    if (out_valid === 1'b1 && !out_stall) begin
      sb.check_output(sample_out);
    end
    if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5);
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) begin
      stall_left--;
    end
  end

  task automatic send_sample(input logic [15:0] s);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_empty();
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input biq_pkg::cfg_reg_e idx, input logic [CFG_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic program_filter(input logic [15:0] b0, input logic [15:0] b1,
                                input logic [15:0] b2, input logic [15:0] a1,
                                input logic [15:0] a2, input logic [4:0] sh);
    set_reg(biq_pkg::REG_COEF_B0, b0);
    set_reg(biq_pkg::REG_COEF_B1, b1);
    set_reg(biq_pkg::REG_COEF_B2, b2);
    set_reg(biq_pkg::REG_COEF_A1, a1);
    set_reg(biq_pkg::REG_COEF_A2, a2);
    set_reg(biq_pkg::REG_FRAC_SHIFT, CFG_W'(sh));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_extreme();
    logic [15:0] ext[4];
    ext = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    return ext[$urandom_range(0, 3)];
  endfunction

  function automatic logic [15:0] rand_sample();
    int mode;
    mode = $urandom_range(0, 19);
    if (mode < 14) return 16'($urandom);
    if (mode < 17) return 16'($urandom_range(0, 127) - 64);
    return pick_extreme();
  endfunction

  function automatic logic [15:0] rand_coef(input int kind, input int sh);
    int span;
    if (kind == 1) begin
      span = 1 << sh;
      return 16'($urandom_range(0, 2 * span) - span);
    end
    if (kind == 2) return pick_extreme();
    return 16'($urandom);
  endfunction

  initial begin
    int kind;
    int sh;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients: output stays zero
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    drain();

    // pass-through
    program_filter(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 5'd0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    drain();

    // extreme coefficients, wrapping sums, shift above range
    program_filter(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 5'd31);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    drain();

    // residue carried across a shift change
    program_filter(16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 5'd7);
    send_sample(16'h1235);
    send_sample(16'h8001);
    send_sample(16'h00FF);
    drain();
    set_reg(biq_pkg::REG_FRAC_SHIFT, CFG_W'(3));
    cfg_we <= 1'b0;
    send_sample(16'h0003);
    send_sample(16'hFFF1);
    send_sample(16'h4321);
    drain();
    set_reg(biq_pkg::REG_FRAC_SHIFT, CFG_W'(0));
    cfg_we <= 1'b0;
    send_sample(16'h0000);
    send_sample(16'h7FFF);

    for (int p = 0; p < 10; p++) begin
      drain();
      kind = $urandom_range(0, 3);
      case (kind)
        0: sh = $urandom_range(0, 31);
        1: sh = $urandom_range(8, 15);
        2: sh = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(30, 31);
        default: sh = $urandom_range(28, 31);
      endcase
      idle_en = (p != 9) && ($urandom_range(0, 3) != 0);
      program_filter(rand_coef(kind, sh), rand_coef(kind, sh), rand_coef(kind, sh),
                     rand_coef(kind, sh), rand_coef(kind, sh), 5'(sh));
      for (int i = 0; i < 70; i++) begin
        if (i == 35 && (p == 2 || $urandom_range(0, 3) == 0)) begin
          wait_empty();
        end
        send_sample(rand_sample());
      end
    end

    wait_empty();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
sv/biq_pkg.sv
sv/biq_front.sv
sv/biq_back.sv
sv/biquad_iir_filter_with_residue.sv
dv/tb_top.sv
